FILE: src/swsfr_pkg.sv
`timescale 1ns / 1ps
package swsfr_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned SEQ_W     = 3;
  localparam int unsigned WS_W      = 3;
  localparam int unsigned SLOTS     = 3;

  localparam logic [WS_W-1:0] WS_RESET  = 3'd4;
  localparam logic [1:0]      DUP_LIMIT = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FN_SEND  = 2'd0,
    FN_ACK   = 2'd1,
    FN_TIMER = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ACT_REFUSED  = 3'd0,
    ACT_TRANSMIT = 3'd1,
    ACT_START    = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_NOTHING  = 3'd4
  } act_e;

  // results planned for one item, emitted slot 0 first
  typedef struct packed {
    logic [1:0]                   last_idx;
    act_e [SLOTS-1:0]             act;
    logic [SLOTS-1:0][SEQ_W-1:0]  seq;
    logic                         use_ram;
    logic                         busy;
  } plan_t;

endpackage

FILE: src/swsfr_in_if.sv
`timescale 1ns / 1ps
interface swsfr_in_if;
  import swsfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [DATA_W-1:0]   payload;
  logic [SEQ_W-1:0]    ack_number;
  logic                ack_valid;
  logic [SEQ_W-1:0]    timer_seq;

  modport source (output valid, func, payload, ack_number, ack_valid, timer_seq,
                  input ready);
  modport sink   (input valid, func, payload, ack_number, ack_valid, timer_seq,
                  output ready);
endinterface

FILE: src/swsfr_out_if.sv
`timescale 1ns / 1ps
interface swsfr_out_if;
  import swsfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic [SEQ_W-1:0]    seq;
  logic [DATA_W-1:0]   payload_out;
  logic                busy_res;
  logic                last;

  modport source (output valid, action, seq, payload_out, busy_res, last,
                  input ready);
  modport sink   (input valid, action, seq, payload_out, busy_res, last,
                  output ready);
endinterface

FILE: src/swsfr_cfg_if.sv
`timescale 1ns / 1ps
interface swsfr_cfg_if;
  import swsfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WS_W-1:0]   win_limit;

  modport source (output valid, win_limit, input ready);
  modport sink   (input valid, win_limit, output ready);
endinterface

FILE: src/swsfr_ram.sv
`timescale 1ns / 1ps
module swsfr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/swsfr_ctrl.sv
`timescale 1ns / 1ps
module swsfr_ctrl #(
  parameter int unsigned SEQ_COUNT    = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  swsfr_in_if.sink                     in_ch,
  swsfr_cfg_if.sink                    cfg_ch,
  output logic                         ram_we_o,
  output logic [$clog2(SEQ_COUNT)-1:0] ram_waddr_o,
  output logic [PAYLOAD_BITS-1:0]      ram_wdata_o,
  output logic                         ram_re_o,
  output logic [$clog2(SEQ_COUNT)-1:0] ram_raddr_o,
  output swsfr_pkg::plan_t             plan_o,
  output logic                         plan_valid_o,
  output logic [PAYLOAD_BITS-1:0]      plan_data_o,
  input  logic                         plan_take_i
);
  import swsfr_pkg::*;

  localparam int unsigned SW = $clog2(SEQ_COUNT);
  localparam int unsigned CW = ((SW > SEQ_W) ? SW : SEQ_W) + 1;
  localparam logic [CW-1:0] SEQ_C  = CW'(SEQ_COUNT);
  localparam logic [SW-1:0] SEQ_MAX = SW'(SEQ_COUNT - 1);

  // input register
  logic                    inq_valid_q;
  logic [FUNC_W-1:0]       func_q;
  logic [PAYLOAD_BITS-1:0] data_q;
  logic [SEQ_W-1:0]        ack_q;
  logic                    ackv_q;
  logic [SEQ_W-1:0]        tseq_q;

  // sender state
  logic [SW-1:0] base_q, base_d;
  logic [SW-1:0] next_q, next_d;
  logic [1:0]    dup_q, dup_d;
  logic          full_q, full_d;
  logic [WS_W-1:0] ws_q;

  plan_t                   plan_q, plan_d;
  logic                    plan_valid_q;
  logic [PAYLOAD_BITS-1:0] plan_data_q;

  logic move;
  logic in_acc;

  logic [CW-1:0] base_c, next_c, ack_c, ws_c, next_inc_c;
  logic [SW-1:0] next_inc, ack_sw;
  logic [1:0]    dup_inc;
  logic          ack_ok;

  function automatic logic [CW-1:0] seq_span(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a >= b) ? (a - b) : (a + SEQ_C - b);
  endfunction

  assign move   = inq_valid_q && (!plan_valid_q || plan_take_i);
  assign in_ch.ready = !inq_valid_q || move;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_acc) begin
      inq_valid_q <= 1'b1;
    end else if (move) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_ch.func;
      data_q <= in_ch.payload[PAYLOAD_BITS-1:0];
      ack_q  <= in_ch.ack_number;
      ackv_q <= in_ch.ack_valid;
      tseq_q <= in_ch.timer_seq;
    end
  end

  assign base_c     = CW'(base_q);
  assign next_c     = CW'(next_q);
  assign ack_c      = CW'(ack_q);
  assign ws_c       = CW'(ws_q);
  assign ack_sw     = ack_c[SW-1:0];
  assign next_inc   = (next_q == SEQ_MAX) ? '0 : next_q + SW'(1);
  assign next_inc_c = CW'(next_inc);
  assign dup_inc    = dup_q + 2'd1;
  assign ack_ok     = ackv_q && (ack_c < SEQ_C);

  always_comb begin
    plan_d          = '0;
    plan_d.act      = {SLOTS{ACT_NOTHING}};
    base_d          = base_q;
    next_d          = next_q;
    dup_d           = dup_q;
    full_d          = full_q;
    ram_we_o        = 1'b0;
    ram_raddr_o     = base_q;
    case (func_q)
      FN_SEND: begin
        if (full_q) begin
          plan_d.act[0] = ACT_REFUSED;
          plan_d.seq[0] = next_c[SEQ_W-1:0];
        end else begin
          ram_we_o      = move;
          plan_d.act[0] = ACT_TRANSMIT;
          plan_d.seq[0] = next_c[SEQ_W-1:0];
          if (base_q == next_q) begin
            plan_d.act[1]   = ACT_START;
            plan_d.seq[1]   = next_c[SEQ_W-1:0];
            plan_d.last_idx = 2'd1;
          end
          next_d = next_inc;
          if (seq_span(next_inc_c, base_c) >= ws_c) begin
            full_d = 1'b1;
          end
        end
      end
      FN_ACK: begin
        ram_raddr_o   = ack_sw;
        plan_d.seq[0] = ack_q;
        if (ack_ok) begin
          if ((seq_span(ack_c, base_c) < ws_c) && (ack_q != base_c[SEQ_W-1:0] ||
              ack_c != base_c)) begin
            full_d        = 1'b0;
            plan_d.act[0] = ACT_STOP;
            plan_d.seq[0] = base_c[SEQ_W-1:0];
            if (ack_c != next_c) begin
              plan_d.act[1]   = ACT_START;
              plan_d.seq[1]   = ack_q;
              plan_d.last_idx = 2'd1;
            end
            dup_d  = 2'd0;
            base_d = ack_sw;
          end else if (dup_inc == DUP_LIMIT) begin
            plan_d.act[0]  = ACT_TRANSMIT;
            plan_d.use_ram = 1'b1;
            dup_d          = 2'd0;
          end else begin
            dup_d = dup_inc;
          end
        end
      end
      FN_TIMER: begin
        plan_d.act[0]   = ACT_STOP;
        plan_d.seq[0]   = tseq_q;
        plan_d.act[1]   = ACT_START;
        plan_d.seq[1]   = tseq_q;
        plan_d.act[2]   = ACT_TRANSMIT;
        plan_d.seq[2]   = base_c[SEQ_W-1:0];
        plan_d.use_ram  = 1'b1;
        plan_d.last_idx = 2'd2;
      end
      default: begin
      end
    endcase
    plan_d.busy = full_d;
  end

  assign ram_waddr_o = next_q;
  assign ram_wdata_o = data_q;
  assign ram_re_o    = move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      next_q       <= '0;
      dup_q        <= 2'd0;
      full_q       <= 1'b0;
      ws_q         <= WS_RESET;
      plan_valid_q <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        ws_q <= cfg_ch.win_limit;
      end
      if (move) begin
        base_q       <= base_d;
        next_q       <= next_d;
        dup_q        <= dup_d;
        full_q       <= full_d;
        plan_valid_q <= 1'b1;
      end else if (plan_take_i) begin
        plan_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      plan_q      <= plan_d;
      plan_data_q <= data_q;
    end
  end

  assign plan_o       = plan_q;
  assign plan_valid_o = plan_valid_q;
  assign plan_data_o  = plan_data_q;

endmodule

FILE: src/swsfr_out.sv
`timescale 1ns / 1ps
module swsfr_out #(
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swsfr_pkg::plan_t        plan_i,
  input  logic                    plan_valid_i,
  input  logic [PAYLOAD_BITS-1:0] plan_data_i,
  input  logic [PAYLOAD_BITS-1:0] ram_rdata_i,
  output logic                    plan_take_o,
  swsfr_out_if.source             out_ch
);
  import swsfr_pkg::*;

  logic [1:0]          idx_q;
  logic                out_valid_q;
  act_e                action_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [DATA_W-1:0]   payload_q;
  logic                busy_q;
  logic                last_q;

  logic                    load;
  logic                    is_last;
  act_e                    act_sel;
  logic [PAYLOAD_BITS-1:0] data_sel;
  logic [DATA_W-1:0]       payload_d;

  assign load        = plan_valid_i && (!out_valid_q || out_ch.ready);
  assign is_last     = (idx_q == plan_i.last_idx);
  assign plan_take_o = load && is_last;
  assign act_sel     = plan_i.act[idx_q];
  assign data_sel    = plan_i.use_ram ? ram_rdata_i : plan_data_i;
  assign payload_d   = (act_sel == ACT_TRANSMIT) ? DATA_W'(data_sel) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q  <= act_sel;
      seq_q     <= plan_i.seq[idx_q];
      payload_q <= payload_d;
      busy_q    <= plan_i.busy;
      last_q    <= is_last;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.action      = action_q;
  assign out_ch.seq         = seq_q;
  assign out_ch.payload_out = payload_q;
  assign out_ch.busy_res    = busy_q;
  assign out_ch.last        = last_q;

endmodule

FILE: src/sliding_window_sender_fast_retransmit.sv
`timescale 1ns / 1ps
// Sender side of a sliding-window link with cumulative acks and fast
// retransmit. Each input item is a send, ack or timer event; it yields one to
// three result items (the last one flagged). An item passes an input
// register, a decode stage whose state and plan registers hold the window
// update and the planned results, and an output register. One item enters
// per cycle as long as each yields a single result and the output does not
// stall; an item with two or three results holds the output sequencer until
// its last result is loaded, so the rate is one item per result produced.
// The payload store is a SEQ_COUNT-entry RAM with a registered read port;
// entries are not cleared after reset. The window limit is taken on the
// config channel at any time and applies to the next decoded item.
module sliding_window_sender_fast_retransmit #(
  parameter int unsigned SEQ_COUNT    = 8,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swsfr_in_if.sink    in_ch,
  swsfr_out_if.source out_ch,
  swsfr_cfg_if.sink   cfg_ch
);
  import swsfr_pkg::*;

  localparam int unsigned SW = $clog2(SEQ_COUNT);

  logic                    ram_we;
  logic [SW-1:0]           ram_waddr;
  logic [PAYLOAD_BITS-1:0] ram_wdata;
  logic                    ram_re;
  logic [SW-1:0]           ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  plan_t                   plan;
  logic                    plan_valid;
  logic [PAYLOAD_BITS-1:0] plan_data;
  logic                    plan_take;

  swsfr_ctrl #(
    .SEQ_COUNT    (SEQ_COUNT),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .plan_o       (plan),
    .plan_valid_o (plan_valid),
    .plan_data_o  (plan_data),
    .plan_take_i  (plan_take)
  );

  swsfr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  swsfr_out #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_i       (plan),
    .plan_valid_i (plan_valid),
    .plan_data_i  (plan_data),
    .ram_rdata_i  (ram_rdata),
    .plan_take_o  (plan_take),
    .out_ch       (out_ch)
  );

endmodule

FILE: src/swsfr_chk.sv
`timescale 1ns / 1ps
module swsfr_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [2:0]                   action_i,
  input logic [swsfr_pkg::DATA_W-1:0] payload_out_i,
  input logic                         busy_res_i,
  input logic                         last_i
);
  import swsfr_pkg::*;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_refuse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i == ACT_REFUSED |-> busy_res_i)
    else $error("refused send while window not full");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i != ACT_TRANSMIT |-> payload_out_i == '0)
    else $error("payload on non-transmit result");

  a_group_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      out_valid_i && busy_res_i == $past(busy_res_i))
    else $error("result group broken or busy flag changed inside group");

endmodule

bind sliding_window_sender_fast_retransmit swsfr_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .action_i      (out_ch.action),
  .payload_out_i (out_ch.payload_out),
  .busy_res_i    (out_ch.busy_res),
  .last_i        (out_ch.last)
);
